@@ design/obe_pkg.sv @@
package obe_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int LABEL_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 4;

    localparam int TRIG_SHIFT = 14;
    localparam int PIX_W      = 10;
    localparam int LABEL_W    = 16;
    localparam int CENT_W     = 14;
    localparam int TRIG_W     = 16;
    localparam int EXT_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [EXT_W-1:0] EXT_MAX = 16'sh7fff;
    localparam logic signed [EXT_W-1:0] EXT_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_LABEL = 3'd0,
        CFG_CENTROID_X   = 3'd1,
        CFG_CENTROID_Y   = 3'd2,
        CFG_AXIS_COS     = 3'd3,
        CFG_AXIS_SIN     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [LABEL_W-1:0] pixel_label;
        logic               last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [EXT_W-1:0]        box_width;
        logic [EXT_W-1:0]        box_height;
        logic signed [EXT_W-1:0] box_cx;
        logic signed [EXT_W-1:0] box_cy;
        logic                    region_found;
    } t_result;

    typedef struct packed {
        logic [LABEL_W-1:0]       target_label;
        logic [CENT_W-1:0]        centroid_x;
        logic [CENT_W-1:0]        centroid_y;
        logic signed [TRIG_W-1:0] axis_cos;
        logic signed [TRIG_W-1:0] axis_sin;
    } t_cfg;

    // one pixel after projection
    typedef struct packed {
        logic signed [EXT_W-1:0] major;
        logic signed [EXT_W-1:0] minor;
        logic                    match;
        logic                    last_pixel;
    } t_proj;

    // final extents of one frame
    typedef struct packed {
        logic signed [EXT_W-1:0] major_min;
        logic signed [EXT_W-1:0] major_max;
        logic signed [EXT_W-1:0] minor_min;
        logic signed [EXT_W-1:0] minor_max;
        logic                    found;
    } t_extent;

    function automatic logic signed [EXT_W-1:0] sat16(input logic signed [63:0] v);
        logic signed [EXT_W-1:0] r;
        if (v > 64'sd32767) begin
            r = EXT_MAX;
        end else if (v < -64'sd32768) begin
            r = EXT_MIN;
        end else begin
            r = v[EXT_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/obe_project.sv @@
module obe_project #(
    parameter int COORD_BITS = obe_pkg::COORD_BITS_DEF,
    parameter int LABEL_BITS = obe_pkg::LABEL_BITS_DEF,
    parameter int FRAC_BITS  = obe_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  obe_pkg::t_pixel i_pixel,
    input  obe_pkg::t_cfg   i_cfg,
    output logic           o_valid,
    input  logic           i_ready,
    output obe_pkg::t_proj  o_proj
);
    import obe_pkg::*;

    localparam int XB   = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
    localparam int CB   = (COORD_BITS + FRAC_BITS < CENT_W) ? COORD_BITS + FRAC_BITS : CENT_W;
    localparam int LC   = (LABEL_BITS < LABEL_W) ? LABEL_BITS : LABEL_W;
    localparam int DW0  = XB + FRAC_BITS;
    localparam int DW   = ((DW0 > CB) ? DW0 : CB) + 1;
    localparam int PW   = DW + TRIG_W;
    localparam int SW   = PW + 1;
    localparam logic [CENT_W-1:0] CMASK = CENT_W'((64'd1 << CB) - 64'd1);

    // stage A: input register
    logic   r_a_vld;
    t_pixel r_a;
    // stage B: products
    logic                 r_b_vld;
    logic signed [PW-1:0] r_xc, r_ys, r_yc, r_xs;
    logic                 r_b_match, r_b_last;
    // stage C: saturated projections
    logic  r_c_vld;
    t_proj r_c;

    logic a_rdy, b_rdy, c_rdy;
    logic [CENT_W-1:0]    cx_m, cy_m;
    logic signed [DW-1:0] dx, dy;
    logic signed [PW-1:0] mul_xc, mul_ys, mul_yc, mul_xs;
    logic                 label_eq;
    logic signed [SW-1:0] maj_sum, min_sum;
    t_proj                n_c;

    assign c_rdy   = !r_c_vld || i_ready;
    assign b_rdy   = !r_b_vld || c_rdy;
    assign a_rdy   = !r_a_vld || b_rdy;
    assign o_stall = !a_rdy;
    assign o_valid = r_c_vld;
    assign o_proj  = r_c;

    assign cx_m = i_cfg.centroid_x & CMASK;
    assign cy_m = i_cfg.centroid_y & CMASK;

    assign dx = $signed(DW'(r_a.pixel_x[XB-1:0]) << FRAC_BITS) - $signed(DW'(cx_m));
    assign dy = $signed(DW'(r_a.pixel_y[XB-1:0]) << FRAC_BITS) - $signed(DW'(cy_m));

    assign mul_xc = PW'(dx) * PW'(i_cfg.axis_cos);
    assign mul_ys = PW'(dy) * PW'(i_cfg.axis_sin);
    assign mul_yc = PW'(dy) * PW'(i_cfg.axis_cos);
    assign mul_xs = PW'(dx) * PW'(i_cfg.axis_sin);

    assign label_eq = (r_a.pixel_label[LC-1:0] == i_cfg.target_label[LC-1:0]);

    assign maj_sum = SW'(r_xc) + SW'(r_ys);
    assign min_sum = SW'(r_yc) - SW'(r_xs);

    always_comb begin
        n_c.major      = sat16(64'(maj_sum >>> TRIG_SHIFT));
        n_c.minor      = sat16(64'(min_sum >>> TRIG_SHIFT));
        n_c.match      = r_b_match;
        n_c.last_pixel = r_b_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (a_rdy) begin
                r_a_vld <= i_valid;
            end
            if (b_rdy) begin
                r_b_vld <= r_a_vld;
            end
            if (c_rdy) begin
                r_c_vld <= r_b_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_rdy && i_valid) begin
            r_a <= i_pixel;
        end
        if (b_rdy && r_a_vld) begin
            r_xc      <= mul_xc;
            r_ys      <= mul_ys;
            r_yc      <= mul_yc;
            r_xs      <= mul_xs;
            r_b_match <= label_eq;
            r_b_last  <= r_a.last_pixel;
        end
        if (c_rdy && r_b_vld) begin
            r_c <= n_c;
        end
    end

endmodule

@@ design/obe_extent.sv @@
module obe_extent (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  obe_pkg::t_proj   i_proj,
    output logic             o_valid,
    input  logic             i_ready,
    output obe_pkg::t_extent o_ext
);
    import obe_pkg::*;

    logic                    r_any;
    logic signed [EXT_W-1:0] r_maj_min, r_maj_max, r_min_min, r_min_max;
    logic                    r_vld;
    t_extent                 r_ext;

    logic    p1_rdy, go;
    t_extent n_ext;

    // only a frame's last pixel needs room downstream
    assign p1_rdy  = !r_vld || i_ready;
    assign o_ready = !i_proj.last_pixel || p1_rdy;
    assign go      = i_valid && o_ready;
    assign o_valid = r_vld;
    assign o_ext   = r_ext;

    always_comb begin
        n_ext.major_min = r_maj_min;
        n_ext.major_max = r_maj_max;
        n_ext.minor_min = r_min_min;
        n_ext.minor_max = r_min_max;
        n_ext.found     = r_any;
        if (i_proj.match) begin
            if (i_proj.major < r_maj_min) begin
                n_ext.major_min = i_proj.major;
            end
            if (i_proj.major > r_maj_max) begin
                n_ext.major_max = i_proj.major;
            end
            if (i_proj.minor < r_min_min) begin
                n_ext.minor_min = i_proj.minor;
            end
            if (i_proj.minor > r_min_max) begin
                n_ext.minor_max = i_proj.minor;
            end
            n_ext.found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any     <= 1'b0;
            r_maj_min <= EXT_MAX;
            r_maj_max <= EXT_MIN;
            r_min_min <= EXT_MAX;
            r_min_max <= EXT_MIN;
            r_vld     <= 1'b0;
        end else begin
            if (go && i_proj.last_pixel) begin
                r_any     <= 1'b0;
                r_maj_min <= EXT_MAX;
                r_maj_max <= EXT_MIN;
                r_min_min <= EXT_MAX;
                r_min_max <= EXT_MIN;
            end else if (go) begin
                r_any     <= n_ext.found;
                r_maj_min <= n_ext.major_min;
                r_maj_max <= n_ext.major_max;
                r_min_min <= n_ext.minor_min;
                r_min_max <= n_ext.minor_max;
            end
            if (go && i_proj.last_pixel) begin
                r_vld <= 1'b1;
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && i_proj.last_pixel) begin
            r_ext <= n_ext;
        end
    end

    a_clear_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (go && i_proj.last_pixel) |=> (!r_any && r_maj_min == EXT_MAX && r_min_max == EXT_MIN))
        else $error("extent state not cleared after frame end");

    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_any |-> (r_maj_min <= r_maj_max && r_min_min <= r_min_max))
        else $error("extent min above max with a match seen");

endmodule

@@ design/obe_center.sv @@
module obe_center #(
    parameter int COORD_BITS = obe_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = obe_pkg::FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  obe_pkg::t_extent i_ext,
    input  obe_pkg::t_cfg    i_cfg,
    output logic             o_valid,
    input  logic             i_stall,
    output obe_pkg::t_result o_result
);
    import obe_pkg::*;

    localparam int CB = (COORD_BITS + FRAC_BITS < CENT_W) ? COORD_BITS + FRAC_BITS : CENT_W;
    localparam logic [CENT_W-1:0] CMASK = CENT_W'((64'd1 << CB) - 64'd1);
    localparam int MW = 2 * EXT_W;
    localparam int SW = EXT_W + 1;
    localparam int OW = MW + 1;

    // stage 1: rotate center offset back
    logic                    r_p_vld;
    logic signed [MW-1:0]    r_mc, r_ns, r_ms, r_nc;
    logic [EXT_W-1:0]        r_w, r_h;
    logic                    r_found;
    // stage 2: output register
    logic                    r_o_vld;
    t_result                 r_out;

    logic                    out_rdy;
    logic signed [SW-1:0]    maj_sum, min_sum;
    logic signed [EXT_W-1:0] om, on;
    logic signed [OW-1:0]    ox_sum, oy_sum;
    logic [CENT_W-1:0]       cx_m, cy_m;
    t_result                 n_out;

    assign out_rdy  = !r_o_vld || !i_stall;
    assign o_ready  = !r_p_vld || out_rdy;
    assign o_valid  = r_o_vld;
    assign o_result = r_out;

    assign maj_sum = SW'(i_ext.major_max) + SW'(i_ext.major_min);
    assign min_sum = SW'(i_ext.minor_max) + SW'(i_ext.minor_min);
    assign om      = EXT_W'(maj_sum >>> 1);
    assign on      = EXT_W'(min_sum >>> 1);

    assign cx_m   = i_cfg.centroid_x & CMASK;
    assign cy_m   = i_cfg.centroid_y & CMASK;
    assign ox_sum = OW'(r_mc) - OW'(r_ns);
    assign oy_sum = OW'(r_ms) + OW'(r_nc);

    always_comb begin
        n_out = '0;
        if (r_found) begin
            n_out.box_width    = r_w;
            n_out.box_height   = r_h;
            n_out.box_cx       = sat16(64'(ox_sum >>> TRIG_SHIFT)
                                       + 64'($signed({1'b0, cx_m})));
            n_out.box_cy       = sat16(64'(oy_sum >>> TRIG_SHIFT)
                                       + 64'($signed({1'b0, cy_m})));
            n_out.region_found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_p_vld <= i_valid;
            end
            if (out_rdy) begin
                r_o_vld <= r_p_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mc    <= MW'(om) * MW'(i_cfg.axis_cos);
            r_ns    <= MW'(on) * MW'(i_cfg.axis_sin);
            r_ms    <= MW'(om) * MW'(i_cfg.axis_sin);
            r_nc    <= MW'(on) * MW'(i_cfg.axis_cos);
            r_w     <= i_ext.major_max - i_ext.major_min;
            r_h     <= i_ext.minor_max - i_ext.minor_min;
            r_found <= i_ext.found;
        end
        if (out_rdy && r_p_vld) begin
            r_out <= n_out;
        end
    end

    a_empty_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !r_out.region_found) |->
            (r_out.box_width == '0 && r_out.box_height == '0
             && r_out.box_cx == '0 && r_out.box_cy == '0))
        else $error("nonzero result for a frame without a match");

endmodule

@@ design/oriented_box_extents.sv @@
// Oriented bounding box of one labelled region in a raster pixel stream.
// Pixel channel: i_valid / o_stall with payload i_pixel; a transaction
// happens on a rising edge with i_valid high and o_stall low. One pixel
// per cycle is taken while o_stall stays low.
// Result channel: o_valid / i_stall with payload o_result. Only a pixel
// with last_pixel set produces a result; it appears on o_valid once that
// pixel has passed every pipeline register, with the frame state cleared.
// Config channel: i_cfg_valid / o_cfg_ready, i_cfg_index selects the
// register (label, centroid x, centroid y, cosine, sine); unknown
// indexes are dropped. o_cfg_ready is always high. Write only while idle.
// Pipeline registers in order: input reg, products, projection and
// saturate, extent update, back rotation products, output reg.
// While the receiver stalls, the result holds and up to two more frame
// results queue inside; pixels keep flowing until a further last pixel
// finds no room, then o_stall rises.
// Synchronous reset: config registers take their defaults, extents are
// cleared and no result is pending.
module oriented_box_extents #(
    parameter int COORD_BITS = obe_pkg::COORD_BITS_DEF,
    parameter int LABEL_BITS = obe_pkg::LABEL_BITS_DEF,
    parameter int FRAC_BITS  = obe_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  obe_pkg::t_pixel                   i_pixel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output obe_pkg::t_result                  o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [obe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [obe_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import obe_pkg::*;

    t_cfg    r_cfg;
    logic    proj_vld, proj_rdy;
    t_proj   proj;
    logic    ext_vld, ext_rdy;
    t_extent ext;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_label <= LABEL_W'(1);
            r_cfg.centroid_x   <= '0;
            r_cfg.centroid_y   <= '0;
            r_cfg.axis_cos     <= 16'sh4000;
            r_cfg.axis_sin     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TARGET_LABEL: r_cfg.target_label <= i_cfg_data;
                CFG_CENTROID_X:   r_cfg.centroid_x   <= i_cfg_data[CENT_W-1:0];
                CFG_CENTROID_Y:   r_cfg.centroid_y   <= i_cfg_data[CENT_W-1:0];
                CFG_AXIS_COS:     r_cfg.axis_cos     <= $signed(i_cfg_data);
                CFG_AXIS_SIN:     r_cfg.axis_sin     <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    obe_project #(
        .COORD_BITS (COORD_BITS),
        .LABEL_BITS (LABEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_project (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pixel (i_pixel),
        .i_cfg   (r_cfg),
        .o_valid (proj_vld),
        .i_ready (proj_rdy),
        .o_proj  (proj)
    );

    obe_extent u_extent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (proj_vld),
        .o_ready (proj_rdy),
        .i_proj  (proj),
        .o_valid (ext_vld),
        .i_ready (ext_rdy),
        .o_ext   (ext)
    );

    obe_center #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_center (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (ext_vld),
        .o_ready  (ext_rdy),
        .i_ext    (ext),
        .i_cfg    (r_cfg),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule

@@ dv/tb_oriented_box_extents.sv @@
module tb_oriented_box_extents;
    timeunit 1ns;
    timeprecision 1ps;

    import obe_pkg::*;

    localparam int IDLE_PCT     = 31;
    localparam int SETTLE_CYC   = 12;
    localparam int PHASE_PIXELS = 180;
    localparam int NUM_PHASES   = 8;
    localparam int CALM_PHASE   = 3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_pixel                i_pixel     = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_result               o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    oriented_box_extents dut (.*);

    // shadow copy of the register file and the running extents
    t_cfg shadow_cfg = '{target_label: 16'd1, centroid_x: '0, centroid_y: '0,
                         axis_cos: 16'sd16384, axis_sin: '0};
    longint major_lo = 32767;
    longint major_hi = -32768;
    longint minor_lo = 32767;
    longint minor_hi = -32768;
    bit     region_seen = 1'b0;

    t_pixel  pixel_q[$];
    t_result box_q[$];
    t_result box_want;
    bit      pix_done   = 1'b0;
    bit      calm       = 1'b0;
    int      fail_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint clamp16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Folds one pixel into the extents; returns 1 with the box when the frame closes.
    function automatic bit measure_pixel(input t_pixel p, output t_result r);
        longint c, s, cx, cy, dx, dy, pmaj, pmin, mid_maj, mid_min;
        c  = $signed(shadow_cfg.axis_cos);
        s  = $signed(shadow_cfg.axis_sin);
        cx = shadow_cfg.centroid_x;
        cy = shadow_cfg.centroid_y;
        r  = '0;
        if (p.pixel_label == shadow_cfg.target_label) begin
            dx   = (longint'(p.pixel_x) << FRAC_BITS_DEF) - cx;
            dy   = (longint'(p.pixel_y) << FRAC_BITS_DEF) - cy;
            pmaj = clamp16((dx * c + dy * s) >>> TRIG_SHIFT);
            pmin = clamp16((dy * c - dx * s) >>> TRIG_SHIFT);
            if (pmaj < major_lo) major_lo = pmaj;
            if (pmaj > major_hi) major_hi = pmaj;
            if (pmin < minor_lo) minor_lo = pmin;
            if (pmin > minor_hi) minor_hi = pmin;
            region_seen = 1'b1;
        end
        if (!p.last_pixel) return 1'b0;
        if (region_seen) begin
            mid_maj        = (major_hi + major_lo) >>> 1;
            mid_min        = (minor_hi + minor_lo) >>> 1;
            r.box_width    = 16'(major_hi - major_lo);
            r.box_height   = 16'(minor_hi - minor_lo);
            r.box_cx       = 16'(clamp16(cx + ((mid_maj * c - mid_min * s) >>> TRIG_SHIFT)));
            r.box_cy       = 16'(clamp16(cy + ((mid_maj * s + mid_min * c) >>> TRIG_SHIFT)));
            r.region_found = 1'b1;
        end
        major_lo    = 32767;
        major_hi    = -32768;
        minor_lo    = 32767;
        minor_hi    = -32768;
        region_seen = 1'b0;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // pixel driver, also drives the result stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            if (!i_valid || pix_done) begin
                if (pixel_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_valid <= 1'b1;
                    i_pixel <= pixel_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // monitor: predicts on pixel transactions, checks result transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_done <= 1'b0;
        end else begin
            pix_done <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                if (measure_pixel(i_pixel, box_want)) box_q.insert(box_q.size(), box_want);
            end
            if (o_valid && !i_stall) begin
                if (box_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end else begin
                    box_want = box_q.pop_front();
                    check_field("box_width", box_want.box_width, o_result.box_width);
                    check_field("box_height", box_want.box_height, o_result.box_height);
                    check_field("box_cx", box_want.box_cx, o_result.box_cx);
                    check_field("box_cy", box_want.box_cy, o_result.box_cy);
                    check_field("region_found", box_want.region_found, o_result.region_found);
                end
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TARGET_LABEL: shadow_cfg.target_label = data;
            CFG_CENTROID_X:   shadow_cfg.centroid_x   = data[CENT_W-1:0];
            CFG_CENTROID_Y:   shadow_cfg.centroid_y   = data[CENT_W-1:0];
            CFG_AXIS_COS:     shadow_cfg.axis_cos     = data;
            CFG_AXIS_SIN:     shadow_cfg.axis_sin     = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_pixel(input int x, input int y, input int lab, input bit last);
        t_pixel p;
        p.pixel_x     = PIX_W'(x);
        p.pixel_y     = PIX_W'(y);
        p.pixel_label = LABEL_W'(lab);
        p.last_pixel  = last;
        pixel_q.insert(pixel_q.size(), p);
    endtask

    // waits until every pixel is sent and every box has come back, then lets the pipe empty
    task automatic drain();
        int guard;
        guard = 0;
        while ((pixel_q.size() != 0 || i_valid || box_q.size() != 0) && guard < 50000) begin
            @(posedge i_clk);
            guard++;
        end
        if (box_q.size() != 0) begin
            $error("%0d expected results never arrived", box_q.size());
            fail_count++;
            box_q.delete();
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic queue_frame(input int len, input int match_pct, input int spread);
        t_pixel p;
        int bx, by, px, py;
        bx = $urandom_range(0, 1023);
        by = $urandom_range(0, 1023);
        for (int k = 0; k < len; k++) begin
            px = bx + $urandom_range(0, spread);
            py = by + $urandom_range(0, spread);
            p.pixel_x     = (px > 1023) ? PIX_W'(1023) : PIX_W'(px);
            p.pixel_y     = (py > 1023) ? PIX_W'(1023) : PIX_W'(py);
            p.pixel_label = ($urandom_range(0, 99) < match_pct) ? shadow_cfg.target_label
                                                               : LABEL_W'($urandom);
            p.last_pixel  = (k == len - 1);
            pixel_q.insert(pixel_q.size(), p);
        end
    endtask

    task automatic random_phase(input bit extreme);
        real ang;
        int  queued, len, pick, pct, spread;
        ang = $urandom_range(0, 35999) * 3.14159265358979 / 18000.0;
        cfg_write(CFG_TARGET_LABEL, CFG_DATA_W'($urandom));
        if (extreme) begin
            cfg_write(CFG_CENTROID_X, $urandom_range(0, 1) ? 16'h3fff : 16'h0000);
            cfg_write(CFG_CENTROID_Y, $urandom_range(0, 1) ? 16'h3fff : 16'h0000);
            cfg_write(CFG_AXIS_COS, CFG_DATA_W'($urandom));
            cfg_write(CFG_AXIS_SIN, CFG_DATA_W'($urandom));
        end else begin
            cfg_write(CFG_CENTROID_X, CFG_DATA_W'($urandom_range(0, 16383)));
            cfg_write(CFG_CENTROID_Y, CFG_DATA_W'($urandom_range(0, 16383)));
            cfg_write(CFG_AXIS_COS, CFG_DATA_W'($rtoi($cos(ang) * 16384.0)));
            cfg_write(CFG_AXIS_SIN, CFG_DATA_W'($rtoi($sin(ang) * 16384.0)));
        end
        queued = 0;
        while (queued < PHASE_PIXELS) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      len = $urandom_range(1, 8);
            else if (pick < 95) len = $urandom_range(9, 40);
            else                len = $urandom_range(41, 120);
            pick = $urandom_range(0, 99);
            if (pick < 15)      pct = 0;    // region absent
            else if (pick < 25) pct = 100;
            else                pct = $urandom_range(40, 99);
            spread = ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, 63);
            queue_frame(len, pct, spread);
            queued += len;
        end
        drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default registers: corner pixels, a frame with no match, mixed labels
        push_pixel(0, 0, 1, 1'b0);
        push_pixel(1023, 1023, 1, 1'b1);
        push_pixel(7, 9, 2, 1'b1);
        push_pixel(1023, 0, 0, 1'b0);
        push_pixel(0, 1023, 65535, 1'b0);
        push_pixel(3, 4, 1, 1'b1);
        drain();

        // unknown register indexes must leave everything untouched
        for (int k = int'(CFG_AXIS_SIN) + 1; k < (1 << CFG_IDX_W); k++)
            cfg_write(CFG_IDX_W'(k), 16'hffff);
        push_pixel(100, 200, 1, 1'b1);
        drain();

        // full-scale trig and centroid: projections saturate
        cfg_write(CFG_TARGET_LABEL, 16'hffff);
        cfg_write(CFG_CENTROID_X, 16'hffff);
        cfg_write(CFG_CENTROID_Y, 16'hffff);
        cfg_write(CFG_AXIS_COS, 16'h8000);
        cfg_write(CFG_AXIS_SIN, 16'h8000);
        push_pixel(0, 0, 65535, 1'b0);
        push_pixel(1023, 1023, 65535, 1'b0);
        push_pixel(0, 1023, 65535, 1'b0);
        push_pixel(1023, 0, 65535, 1'b1);
        drain();

        cfg_write(CFG_TARGET_LABEL, 16'h0000);
        cfg_write(CFG_CENTROID_X, 16'h0000);
        cfg_write(CFG_CENTROID_Y, 16'h0000);
        cfg_write(CFG_AXIS_COS, 16'h7fff);
        cfg_write(CFG_AXIS_SIN, 16'h7fff);
        push_pixel(1023, 1023, 0, 1'b0);
        push_pixel(0, 0, 0, 1'b1);
        push_pixel(512, 300, 0, 1'b1);
        drain();

        cfg_write(CFG_TARGET_LABEL, 16'd1234);
        cfg_write(CFG_CENTROID_X, 16'd8000);
        cfg_write(CFG_CENTROID_Y, 16'd4000);
        cfg_write(CFG_AXIS_COS, -16'sd16384);
        cfg_write(CFG_AXIS_SIN, 16'sd16384);
        push_pixel(500, 250, 1234, 1'b0);
        push_pixel(510, 240, 1234, 1'b0);
        push_pixel(490, 260, 77, 1'b1);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            calm = (ph == CALM_PHASE);
            random_phase(ph == 0 || ph == 5);
        end
        calm = 1'b0;
        drain();

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
